>>> hdl/oal_pkg.sv
// Shared types, codes and limits for the ordered array list.
package oal_pkg;

    localparam int CAPACITY_DEF    = 16;
    localparam int ENTRY_WIDTH_DEF = 32;
    localparam int CAPACITY_MAX    = 1024;
    // Index and count width that covers any capacity in range.
    localparam int IDX_W_MAX       = $clog2(CAPACITY_MAX + 1);

    typedef enum logic [2:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_INSERT     = 3'd4,
        MODE_ERASE      = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_BAD_POS = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SH_NONE,
        SH_UP,
        SH_DOWN,
        SH_APPEND
    } shift_op_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_LOWER,
        CELL_FROM_UPPER
    } cell_cmd_t;

    // Command broadcast to every cell in the chain.
    typedef struct packed {
        shift_op_t            op;
        logic [IDX_W_MAX-1:0] at;
        logic [IDX_W_MAX-1:0] count;
    } shift_cmd_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [4:0]  position;
        logic [31:0] element_data;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [4:0]  entry_count;
        logic [31:0] entry_at_position;
    } res_t;

endpackage

>>> hdl/oal_cell.sv
// One entry cell of the list chain: holds, loads or takes a neighbor's entry.
module oal_cell #(
    parameter int IDX         = 0,
    parameter int ENTRY_WIDTH = oal_pkg::ENTRY_WIDTH_DEF
) (
    input  logic                   aclk,
    input  oal_pkg::shift_cmd_t    cmd,
    input  logic [ENTRY_WIDTH-1:0] din,
    input  logic [ENTRY_WIDTH-1:0] lower_entry,
    input  logic [ENTRY_WIDTH-1:0] upper_entry,
    output logic [ENTRY_WIDTH-1:0] entry
);
    import oal_pkg::*;

    localparam logic [IDX_W_MAX-1:0] MY_IDX  = IDX_W_MAX'(IDX);
    localparam logic [IDX_W_MAX-1:0] NXT_IDX = IDX_W_MAX'(IDX + 1);

    logic [ENTRY_WIDTH-1:0] entry_reg;
    logic [ENTRY_WIDTH-1:0] entry_next;
    cell_cmd_t              sel;

    always_comb begin
        sel = CELL_HOLD;
        case (cmd.op)
            SH_UP: begin
                if (MY_IDX == cmd.at) begin
                    sel = CELL_LOAD;
                end else if (MY_IDX > cmd.at && MY_IDX <= cmd.count) begin
                    sel = CELL_FROM_LOWER;
                end
            end
            SH_DOWN: begin
                if (MY_IDX >= cmd.at && NXT_IDX < cmd.count) begin
                    sel = CELL_FROM_UPPER;
                end
            end
            SH_APPEND: begin
                if (MY_IDX == cmd.at) begin
                    sel = CELL_LOAD;
                end
            end
            default: sel = CELL_HOLD;
        endcase
    end

    always_comb begin
        case (sel)
            CELL_LOAD:       entry_next = din;
            CELL_FROM_LOWER: entry_next = lower_entry;
            CELL_FROM_UPPER: entry_next = upper_entry;
            default:         entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

>>> hdl/oal_ctrl.sv
// Operation decode: status, next count and the shift command for the chain.
module oal_ctrl #(
    parameter int CAPACITY = oal_pkg::CAPACITY_DEF
) (
    input  logic [2:0]                     mode,
    input  logic [4:0]                     position,
    input  logic [oal_pkg::IDX_W_MAX-1:0]  count,
    output oal_pkg::status_t               status,
    output oal_pkg::shift_cmd_t            cmd,
    output logic [oal_pkg::IDX_W_MAX-1:0]  count_next
);
    import oal_pkg::*;

    localparam logic [IDX_W_MAX-1:0] CAP = IDX_W_MAX'(CAPACITY);

    logic [IDX_W_MAX-1:0] pos_x;
    logic                 full;
    logic                 empty;

    assign pos_x = IDX_W_MAX'(position);
    assign full  = count >= CAP;
    assign empty = count == '0;

    always_comb begin
        status     = ST_OK;
        cmd.op     = SH_NONE;
        cmd.at     = '0;
        cmd.count  = count;
        count_next = count;
        case (mode)
            MODE_PUSH_FRONT: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    cmd.op     = SH_UP;
                    count_next = count + 1'b1;
                end
            end
            MODE_PUSH_BACK: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    cmd.op     = SH_APPEND;
                    cmd.at     = count;
                    count_next = count + 1'b1;
                end
            end
            MODE_POP_FRONT: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    cmd.op     = SH_DOWN;
                    count_next = count - 1'b1;
                end
            end
            MODE_POP_BACK: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    count_next = count - 1'b1;
                end
            end
            MODE_INSERT: begin
                if (pos_x > count) begin
                    status = ST_BAD_POS;
                end else if (full) begin
                    status = ST_FULL;
                end else begin
                    cmd.op     = SH_UP;
                    cmd.at     = pos_x;
                    count_next = count + 1'b1;
                end
            end
            MODE_ERASE: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else if (pos_x >= count) begin
                    status = ST_BAD_POS;
                end else begin
                    cmd.op     = SH_DOWN;
                    cmd.at     = pos_x;
                    count_next = count - 1'b1;
                end
            end
            default: status = ST_BAD_POS;
        endcase
    end

endmodule

>>> hdl/ordered_array_list.sv
// Top level of the ordered array list: cell chain, count, readout and result register.
// A request moves from the readout stage into the result register. Throughput: one request
// per cycle unless the result register stalls; every chain cell shifts, loads or holds in
//   the same cycle, so any insert, erase, push or pop finishes in the cycle it is accepted.
// Reset (aresetn low, synchronous): clears the entry count and the valid flags of the
//   readout stage and the result register; entry cells are not cleared.
module ordered_array_list #(
    parameter int CAPACITY    = oal_pkg::CAPACITY_DEF,
    parameter int ENTRY_WIDTH = oal_pkg::ENTRY_WIDTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  oal_pkg::req_t s_req,
    output logic          m_valid,
    input  logic          m_ready,
    output oal_pkg::res_t m_res
);
    import oal_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    // Position is five bits wide, so only the first 32 cells can ever be reported.
    localparam int RD_N  = (CAPACITY < 32) ? CAPACITY : 32;
    localparam int RD_W  = (RD_N > 1) ? $clog2(RD_N) : 1;

    logic                   s_accept;
    logic                   out_free;

    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [IDX_W_MAX-1:0]   count_x;
    logic [IDX_W_MAX-1:0]   ctrl_count_next;

    status_t                dec_status;
    shift_cmd_t             dec_cmd;
    shift_cmd_t             chain_cmd;

    logic [ENTRY_WIDTH-1:0] din;
    logic [ENTRY_WIDTH-1:0] cell_q [CAPACITY];

    // Readout stage: remembers the request until the updated chain is sampled.
    logic                   p1_valid_reg;
    logic [4:0]             p1_pos_reg;
    status_t                p1_status_reg;

    logic                   m_valid_reg;
    res_t                   m_res_reg;
    res_t                   m_res_next;

    logic [RD_W-1:0]        rd_idx;
    logic [ENTRY_WIDTH-1:0] rd_entry;

    // The readout stage hands over whenever the result register is empty or draining,
    // so a new request may enter in the same cycle.
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !p1_valid_reg || out_free;
    assign s_accept = s_valid && s_ready;

    assign count_x = IDX_W_MAX'(count_reg);
    assign din     = ENTRY_WIDTH'(s_req.element_data);

    oal_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .mode       (s_req.mode),
        .position   (s_req.position),
        .count      (count_x),
        .status     (dec_status),
        .cmd        (dec_cmd),
        .count_next (ctrl_count_next)
    );

    // Drive the chain only for an accepted request; otherwise every cell holds.
    always_comb begin
        chain_cmd = dec_cmd;
        if (!s_accept) begin
            chain_cmd.op = SH_NONE;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (s_accept) begin
            count_next = CNT_W'(ctrl_count_next);
        end
    end

    // Cell chain: each cell sees its lower and upper neighbor; the ends see zero.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [ENTRY_WIDTH-1:0] lower_entry;
        logic [ENTRY_WIDTH-1:0] upper_entry;

        if (i == 0) begin : g_first
            assign lower_entry = '0;
        end else begin : g_mid_lo
            assign lower_entry = cell_q[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign upper_entry = '0;
        end else begin : g_mid_hi
            assign upper_entry = cell_q[i+1];
        end

        oal_cell #(
            .IDX         (i),
            .ENTRY_WIDTH (ENTRY_WIDTH)
        ) u_cell (
            .aclk        (aclk),
            .cmd         (chain_cmd),
            .din         (din),
            .lower_entry (lower_entry),
            .upper_entry (upper_entry),
            .entry       (cell_q[i])
        );
    end

    // Sample the entry at the held position from the chain as it stands after the
    // request; count_reg and the cells still hold that request's outcome here.
    assign rd_idx   = RD_W'(p1_pos_reg);
    assign rd_entry = cell_q[rd_idx];

    always_comb begin
        m_res_next.status            = p1_status_reg;
        m_res_next.entry_count       = 5'(count_reg);
        m_res_next.entry_at_position = '0;
        if (CNT_W'(p1_pos_reg) < count_reg && 32'(p1_pos_reg) < 32'(CAPACITY)) begin
            m_res_next.entry_at_position = 32'(rd_entry);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            // Advance the readout stage into the result register when there is room.
            if (p1_valid_reg && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (s_accept) begin
                p1_valid_reg <= 1'b1;
            end else if (out_free) begin
                p1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_pos_reg    <= s_req.position;
            p1_status_reg <= dec_status;
        end
        if (p1_valid_reg && out_free) begin
            m_res_reg <= m_res_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

    // The count never exceeds the capacity.
    a_count_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // A rejected request leaves the count unchanged.
    a_reject_holds : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && dec_status != ST_OK) |=> (count_reg == $past(count_reg)))
        else $error("rejected request changed the count");

    // A waiting readout stage with a stalled result register blocks new requests.
    a_stall_blocks : assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && m_valid_reg && !m_ready) |-> !s_ready)
        else $error("request accepted while readout stage is stalled");

    // An accepted ok push or insert grows the count by one.
    a_push_grows : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && dec_status == ST_OK && (dec_cmd.op == SH_UP || dec_cmd.op == SH_APPEND))
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("successful push did not grow the count");

endmodule
